// ----- sv/jsm_pkg.sv -----
`default_nettype none
package jsm_pkg;

  localparam int unsigned COUNT_MAX  = 255;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned PT_BITS    = 16;
  localparam int unsigned ANGLE_BITS = 12;
  localparam int unsigned ETA_W      = 11;
  localparam int unsigned FRAC_W     = 11;
  localparam int unsigned HT_BITS    = 24;
  localparam int unsigned MHT_BITS   = 25;
  localparam int unsigned MAG_BITS   = 24;
  localparam int unsigned EMF_ETA_LIMIT = 260;
  localparam int unsigned CORDIC_STEPS  = 20;
  localparam int unsigned SQRT_STEPS    = 25;
  localparam int unsigned CORDIC_W      = 36;
  localparam int unsigned SQ_W          = 50;
  localparam int unsigned CFG_IDX_W     = 8;
  localparam int unsigned CFG_DATA_W    = 16;
  localparam int unsigned QUEUE_DEPTH   = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOOSE_PT_MIN  = 8'd0,
    REG_TIGHT_PT_MIN  = 8'd1,
    REG_LOOSE_ETA_MAX = 8'd2,
    REG_TIGHT_ETA_MAX = 8'd3,
    REG_BTAG_ETA_MAX  = 8'd4,
    REG_BTAG_THRESH   = 8'd5,
    REG_HPD_FRAC_MAX  = 8'd6,
    REG_EMF_MIN       = 8'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [PT_BITS-1:0]      loose_pt_min;
    logic [PT_BITS-1:0]      tight_pt_min;
    logic [9:0]              loose_eta_max;
    logic [9:0]              tight_eta_max;
    logic [9:0]              btag_eta_max;
    logic signed [10:0]      btag_threshold;
    logic [FRAC_W-1:0]       hpd_fraction_max;
    logic [FRAC_W-1:0]       emf_min;
  } cfg_t;

  // Event summary handed from the front to the back.
  typedef struct packed {
    logic [CNT_W-1:0]             n_loose;
    logic [CNT_W-1:0]             n_tight;
    logic [CNT_W-1:0]             n_btag;
    logic [CNT_W-1:0]             n_bjet;
    logic [HT_BITS-1:0]           ht;
    logic signed [MHT_BITS-1:0]   mx;
    logic signed [MHT_BITS-1:0]   my;
    logic [2:0][ANGLE_BITS-1:0]   phi;
    logic [1:0]                   njets;
  } snap_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_SUM,
    B_ITER,
    B_FIN
  } back_state_e;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (32'(c) < COUNT_MAX) ? CNT_W'(c + 1'b1) : c;
  endfunction

  // CORDIC arctangent, 2^32 per turn.
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- sv/jsm_if.sv -----
`default_nettype none
interface jsm_jet_if;
  import jsm_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [PT_BITS-1:0]         jet_pt;
  logic signed [ETA_W-1:0]    jet_eta;
  logic signed [ANGLE_BITS-1:0] jet_phi;
  logic signed [PT_BITS:0]    jet_px;
  logic signed [PT_BITS:0]    jet_py;
  logic [7:0]                 hits90;
  logic [FRAC_W-1:0]          hpd_fraction;
  logic [FRAC_W-1:0]          em_fraction;
  logic signed [10:0]         btag_disc;
  logic signed [5:0]          parton_flavour;
  logic                       last_jet;
  modport source (output valid, jet_pt, jet_eta, jet_phi, jet_px, jet_py, hits90,
                  hpd_fraction, em_fraction, btag_disc, parton_flavour, last_jet,
                  input ready);
  modport sink (input valid, jet_pt, jet_eta, jet_phi, jet_px, jet_py, hits90,
                hpd_fraction, em_fraction, btag_disc, parton_flavour, last_jet,
                output ready);
endinterface

interface jsm_res_if;
  import jsm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CNT_W-1:0]      n_loose;
  logic [CNT_W-1:0]      n_tight;
  logic [CNT_W-1:0]      n_btag;
  logic [CNT_W-1:0]      n_bjet;
  logic [HT_BITS-1:0]    ht_sum;
  logic [MAG_BITS-1:0]   mht_mag;
  logic [ANGLE_BITS-1:0] min_dphi;
  logic                  dphi_valid;
  modport source (output valid, n_loose, n_tight, n_btag, n_bjet, ht_sum, mht_mag,
                  min_dphi, dphi_valid, input ready);
  modport sink (input valid, n_loose, n_tight, n_btag, n_bjet, ht_sum, mht_mag,
                min_dphi, dphi_valid, output ready);
endinterface

interface jsm_cfg_if;
  import jsm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- sv/jsm_front.sv -----
`default_nettype none
module jsm_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  jsm_jet_if.sink           jet_i,
  input  jsm_pkg::cfg_t     cfg_i,
  input  wire logic         full_i,
  output logic              push_o,
  output jsm_pkg::snap_t    snap_o
);
  import jsm_pkg::*;

  logic [CNT_W-1:0] loose_q, loose_d, tight_q, tight_d;
  logic [CNT_W-1:0] btag_q, btag_d, bjet_q, bjet_d;
  logic [HT_BITS-1:0] ht_q, ht_d;
  logic signed [MHT_BITS-1:0] mx_q, mx_d, my_q, my_d;
  logic [2:0][PT_BITS-1:0] lpt_q, lpt_d;
  logic [2:0][ANGLE_BITS-1:0] lphi_q, lphi_d;

  logic accept, good, bcut, loose, tight;
  logic [ETA_W-1:0] aeta;
  logic signed [MHT_BITS:0] mx_s, my_s;
  logic [HT_BITS:0] ht_s;
  logic signed [MHT_BITS:0] lim_hi, lim_lo;

  assign jet_i.ready = !full_i;
  assign accept = jet_i.valid && jet_i.ready;

  always_comb begin
    aeta = jet_i.jet_eta[ETA_W-1] ? ETA_W'(-jet_i.jet_eta) : ETA_W'(jet_i.jet_eta);
    good = (jet_i.hits90 > 8'd1) && (jet_i.hpd_fraction < cfg_i.hpd_fraction_max) &&
           !((aeta < ETA_W'(EMF_ETA_LIMIT)) && (jet_i.em_fraction <= cfg_i.emf_min));
    bcut = good && (aeta < ETA_W'(cfg_i.btag_eta_max)) &&
           (jet_i.jet_pt > cfg_i.loose_pt_min);
    loose = good && (jet_i.jet_pt > cfg_i.loose_pt_min) &&
            (aeta < ETA_W'(cfg_i.loose_eta_max));
    tight = loose && (jet_i.jet_pt > cfg_i.tight_pt_min) &&
            (aeta < ETA_W'(cfg_i.tight_eta_max));
    lim_hi = (MHT_BITS+1)'({1'b0, {(MHT_BITS-1){1'b1}}});
    lim_lo = (MHT_BITS+1)'({2'b11, {(MHT_BITS-1){1'b0}}});
    mx_s = (MHT_BITS+1)'(mx_q) - (MHT_BITS+1)'(jet_i.jet_px);
    my_s = (MHT_BITS+1)'(my_q) - (MHT_BITS+1)'(jet_i.jet_py);
    ht_s = (HT_BITS+1)'(ht_q) + (HT_BITS+1)'(jet_i.jet_pt);

    loose_d = loose_q; tight_d = tight_q; btag_d = btag_q; bjet_d = bjet_q;
    ht_d = ht_q; mx_d = mx_q; my_d = my_q; lpt_d = lpt_q; lphi_d = lphi_q;

    if (accept) begin
      if (bcut) begin
        if (jet_i.btag_disc >= cfg_i.btag_threshold) btag_d = sat_inc(btag_q);
        if (jet_i.parton_flavour == 6'sd5 || jet_i.parton_flavour == -6'sd5) begin
          bjet_d = sat_inc(bjet_q);
        end
      end
      if (loose) begin
        loose_d = sat_inc(loose_q);
        mx_d = (mx_s > lim_hi) ? MHT_BITS'(lim_hi) :
               (mx_s < lim_lo) ? MHT_BITS'(lim_lo) : MHT_BITS'(mx_s);
        my_d = (my_s > lim_hi) ? MHT_BITS'(lim_hi) :
               (my_s < lim_lo) ? MHT_BITS'(lim_lo) : MHT_BITS'(my_s);
      end
      if (tight) begin
        tight_d = sat_inc(tight_q);
        ht_d = ht_s[HT_BITS] ? {HT_BITS{1'b1}} : ht_s[HT_BITS-1:0];
        if (jet_i.jet_pt > lpt_q[0]) begin
          lpt_d[2] = lpt_q[1]; lphi_d[2] = lphi_q[1];
          lpt_d[1] = lpt_q[0]; lphi_d[1] = lphi_q[0];
          lpt_d[0] = jet_i.jet_pt; lphi_d[0] = jet_i.jet_phi;
        end else if (jet_i.jet_pt > lpt_q[1]) begin
          lpt_d[2] = lpt_q[1]; lphi_d[2] = lphi_q[1];
          lpt_d[1] = jet_i.jet_pt; lphi_d[1] = jet_i.jet_phi;
        end else if (jet_i.jet_pt > lpt_q[2]) begin
          lpt_d[2] = jet_i.jet_pt; lphi_d[2] = jet_i.jet_phi;
        end
      end
    end

    push_o = accept && jet_i.last_jet;
    snap_o.n_loose = loose_d;
    snap_o.n_tight = tight_d;
    snap_o.n_btag = btag_d;
    snap_o.n_bjet = bjet_d;
    snap_o.ht = ht_d;
    snap_o.mx = mx_d;
    snap_o.my = my_d;
    snap_o.phi = lphi_d;
    snap_o.njets = (tight_d < CNT_W'(3)) ? 2'(tight_d) : 2'd3;

    // The event is closed: start the next one from zero.
    if (push_o) begin
      loose_d = '0; tight_d = '0; btag_d = '0; bjet_d = '0;
      ht_d = '0; mx_d = '0; my_d = '0; lpt_d = '0; lphi_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loose_q <= '0; tight_q <= '0; btag_q <= '0; bjet_q <= '0;
      ht_q <= '0; mx_q <= '0; my_q <= '0; lpt_q <= '0; lphi_q <= '0;
    end else begin
      loose_q <= loose_d; tight_q <= tight_d; btag_q <= btag_d; bjet_q <= bjet_d;
      ht_q <= ht_d; mx_q <= mx_d; my_q <= my_d; lpt_q <= lpt_d; lphi_q <= lphi_d;
    end
  end
endmodule
`default_nettype wire

// ----- sv/jsm_fifo.sv -----
`default_nettype none
module jsm_fifo (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  jsm_pkg::snap_t data_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output logic           valid_o,
  output jsm_pkg::snap_t data_o
);
  import jsm_pkg::*;

  snap_t mem_q [QUEUE_DEPTH];
  logic wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i) rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end
endmodule
`default_nettype wire

// ----- sv/jsm_back.sv -----
`default_nettype none
module jsm_back (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      valid_i,
  input  jsm_pkg::snap_t snap_i,
  output logic           pop_o,
  jsm_res_if.source      res_o
);
  import jsm_pkg::*;

  back_state_e state_q, state_d;
  snap_t snap_q;
  logic [4:0] step_q, step_d;
  logic signed [2*MHT_BITS-1:0] sqx_q, sqy_q;
  logic [SQ_W-1:0] rem_q, rem_d, res_q, res_d, bit_q, bit_d;
  logic signed [CORDIC_W-1:0] x_q, x_d, y_q, y_d, dx, dy, x0, y0;
  logic [31:0] a_q, a_d;
  logic zero_q;
  logic out_v_q, out_v_d;
  logic load_out;
  logic [SQ_W-1:0] trial, mag_r;
  logic [MAG_BITS-1:0] mag_o;
  logic [ANGLE_BITS-1:0] best;
  logic [31:0] mang, d;
  logic [ANGLE_BITS:0] code;
  logic [ANGLE_BITS-1:0] best_d_q;
  logic dval_q;
  logic [MAG_BITS-1:0] mag_q;

  // Entry values: scale by 256; the idle state folds a negative x by half a turn.
  always_comb begin
    x0 = CORDIC_W'(snap_i.mx) <<< 8;
    y0 = CORDIC_W'(snap_i.my) <<< 8;
  end

  always_comb begin
    state_d = state_q; step_d = step_q;
    rem_d = rem_q; res_d = res_q; bit_d = bit_q;
    x_d = x_q; y_d = y_q; a_d = a_q;
    pop_o = 1'b0; load_out = 1'b0;
    out_v_d = out_v_q && !res_o.ready;
    dx = y_q >>> step_q;
    dy = x_q >>> step_q;
    trial = res_q + bit_q;
    unique case (state_q)
      B_IDLE: begin
        if (valid_i) begin
          pop_o = 1'b1;
          state_d = B_MUL;
          if (x0 < 0) begin
            x_d = -x0; y_d = -y0; a_d = 32'h80000000;
          end else begin
            x_d = x0; y_d = y0; a_d = '0;
          end
        end
      end
      B_MUL: state_d = B_SUM;
      B_SUM: begin
        rem_d = SQ_W'(sqx_q) + SQ_W'(sqy_q);
        res_d = '0;
        bit_d = SQ_W'(1) << (2*(SQRT_STEPS-1));
        step_d = '0;
        state_d = B_ITER;
      end
      B_ITER: begin
        if (rem_q >= trial) begin
          rem_d = rem_q - trial;
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (32'(step_q) < CORDIC_STEPS) begin
          if (y_q > 0) begin
            x_d = x_q + dx; y_d = y_q - dy; a_d = a_q + atan_turn(step_q);
          end else begin
            x_d = x_q - dx; y_d = y_q + dy; a_d = a_q - atan_turn(step_q);
          end
        end
        step_d = step_q + 5'd1;
        if (32'(step_q) == SQRT_STEPS - 1) state_d = B_FIN;
      end
      B_FIN: begin
        if (!out_v_q || res_o.ready) begin
          load_out = 1'b1;
          out_v_d = 1'b1;
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // Magnitude rounding and the folded angle to each leading jet.
  always_comb begin
    mag_r = (rem_q > res_q) ? res_q + SQ_W'(1) : res_q;
    mag_o = (mag_r > SQ_W'({MAG_BITS{1'b1}})) ? {MAG_BITS{1'b1}} : mag_r[MAG_BITS-1:0];
    mang = zero_q ? 32'h0 : a_q;
    best = '0;
    d = '0;
    code = '0;
    for (int i = 0; i < 3; i++) begin
      d = {snap_q.phi[i], {(32-ANGLE_BITS){1'b0}}} - mang;
      if (d > 32'h80000000) d = -d;
      code = (ANGLE_BITS+1)'((33'(d) + 33'(1 << (31-ANGLE_BITS))) >> (32-ANGLE_BITS));
      if (2'(i) < snap_q.njets) begin
        if (i == 0 || code[ANGLE_BITS-1:0] < best) best = code[ANGLE_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      snap_q <= snap_i;
      zero_q <= (snap_i.mx == '0) && (snap_i.my == '0);
    end
    if (state_q == B_MUL) begin
      sqx_q <= snap_q.mx * snap_q.mx;
      sqy_q <= snap_q.my * snap_q.my;
    end
    rem_q <= rem_d; res_q <= res_d; bit_q <= bit_d;
    x_q <= x_d; y_q <= y_d; a_q <= a_d;
    if (load_out) begin
      mag_q <= mag_o;
      best_d_q <= best;
      dval_q <= (snap_q.njets != 2'd0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE; step_q <= '0; out_v_q <= 1'b0;
    end else begin
      state_q <= state_d; step_q <= step_d; out_v_q <= out_v_d;
    end
  end

  // The summary register keeps its own copy of the counts.
  snap_t out_snap_q;
  always_ff @(posedge clk_i) begin
    if (load_out) out_snap_q <= snap_q;
  end

  assign res_o.valid      = out_v_q;
  assign res_o.n_loose    = out_snap_q.n_loose;
  assign res_o.n_tight    = out_snap_q.n_tight;
  assign res_o.n_btag     = out_snap_q.n_btag;
  assign res_o.n_bjet     = out_snap_q.n_bjet;
  assign res_o.ht_sum     = out_snap_q.ht;
  assign res_o.mht_mag    = mag_q;
  assign res_o.min_dphi   = best_d_q;
  assign res_o.dphi_valid = dval_q;
endmodule
`default_nettype wire

// ----- sv/jet_sum_min_dphi_engine.sv -----
`default_nettype none
// Channel   Dir   Handshake      Payload
// jet_i     in    valid/ready    one jet word, last_jet closes the event
// res_o     out   valid/ready    one event summary word per event
// cfg_i     in    valid/ready    register index and write data
//
// The front takes one jet word per cycle while the queue is not full and holds the running sums.
// The back takes one event at a time from the queue: square, add, then 25 steps of
// the shared square root and CORDIC sequencer, and then min dphi at the output load.
// A two-entry queue of event summaries lets the front keep taking jets
// while the back finishes; the front stalls only when that queue is full.
// Reset clears all counters, sums and control state; config returns to
// its defaults. A stalled summary sits in the output register.
module jet_sum_min_dphi_engine (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  jsm_jet_if.sink   jet_i,
  jsm_cfg_if.sink   cfg_i,
  jsm_res_if.source res_o
);
  import jsm_pkg::*;

  cfg_t cfg_q;
  logic push, full, pop, q_valid;
  snap_t push_snap, pop_snap;

  // Config writes are always taken; unknown indexes are dropped.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.loose_pt_min     <= PT_BITS'(120);
      cfg_q.tight_pt_min     <= PT_BITS'(200);
      cfg_q.loose_eta_max    <= 10'd500;
      cfg_q.tight_eta_max    <= 10'd250;
      cfg_q.btag_eta_max     <= 10'd240;
      cfg_q.btag_threshold   <= 11'sd174;
      cfg_q.hpd_fraction_max <= 11'd1004;
      cfg_q.emf_min          <= 11'd10;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_LOOSE_PT_MIN:  cfg_q.loose_pt_min     <= cfg_i.data[PT_BITS-1:0];
        REG_TIGHT_PT_MIN:  cfg_q.tight_pt_min     <= cfg_i.data[PT_BITS-1:0];
        REG_LOOSE_ETA_MAX: cfg_q.loose_eta_max    <= cfg_i.data[9:0];
        REG_TIGHT_ETA_MAX: cfg_q.tight_eta_max    <= cfg_i.data[9:0];
        REG_BTAG_ETA_MAX:  cfg_q.btag_eta_max     <= cfg_i.data[9:0];
        REG_BTAG_THRESH:   cfg_q.btag_threshold   <= cfg_i.data[10:0];
        REG_HPD_FRAC_MAX:  cfg_q.hpd_fraction_max <= cfg_i.data[10:0];
        REG_EMF_MIN:       cfg_q.emf_min          <= cfg_i.data[10:0];
        default: ;
      endcase
    end
  end

  jsm_front u_front (
    .clk_i, .rst_ni, .jet_i, .cfg_i(cfg_q), .full_i(full),
    .push_o(push), .snap_o(push_snap)
  );

  jsm_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(push_snap), .full_o(full),
    .pop_i(pop), .valid_o(q_valid), .data_o(pop_snap)
  );

  jsm_back u_back (
    .clk_i, .rst_ni, .valid_i(q_valid), .snap_i(pop_snap), .pop_o(pop), .res_o
  );
endmodule
`default_nettype wire
